// ===== rtl/qau_pkg.sv =====
// Shared types and codes for the quaternion arithmetic unit.
// No dependencies; every other rtl file but qau_div_lane refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_NEG   = 4'd2,
        OP_MUL   = 4'd3,
        OP_SCALE = 4'd4,
        OP_DIVS  = 4'd5,
        OP_CONJ  = 4'd6,
        OP_NORM  = 4'd7,
        OP_NRM   = 4'd8,
        OP_INV   = 4'd9,
        OP_ROT   = 4'd10
    } op_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // Per-stage control that travels with each beat.
    typedef struct packed {
        logic vld;
        op_t  op;
        logic dz;
    } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/qau_front.sv =====
// Front end: four lanes of products, sums, rotation terms and saturation.
// Depends on qau_pkg. Four register stages, advanced together by adv.
`timescale 1ns / 1ps
`default_nettype none

module qau_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  qau_pkg::ctl_t        ctl_i,
    input  logic signed [W-1:0]  a_i [4],
    input  logic signed [W-1:0]  b_i [4],
    output qau_pkg::ctl_t        ctl_o,
    output logic signed [W-1:0]  a_o [4],
    output logic signed [W-1:0]  b0_o,
    output logic [2*W:0]         s_o,
    output logic signed [W-1:0]  r_o [4],
    output logic                 sat_o
);

    localparam int PW  = 2 * W;
    localparam int MW  = 2 * W + 2;
    localparam int TW  = 2 * W + 2 - F;
    localparam int TLW = TW / 2;
    localparam int THW = TW - TLW;
    localparam int LPW = W + TLW + 1;
    localparam int HPW = W + THW;
    localparam int VW  = W + TW + F + 2;
    localparam int SSW = 2 * W + 1;

    // stage 1
    qau_pkg::ctl_t       ctl1_reg, ctl1_next;
    logic signed [W-1:0] a1_reg [4];
    logic signed [W-1:0] b1_reg [4];
    logic signed [PW-1:0] p_reg [4][4], p_next [4][4];
    logic signed [PW-1:0] q_reg [4], q_next [4];
    logic                a_zero;

    // stage 2
    qau_pkg::ctl_t       ctl2_reg;
    logic signed [W-1:0] a2_reg [4];
    logic signed [W-1:0] b2_reg [3];
    logic [SSW-1:0]      s2_reg, s2_next;
    logic signed [VW-1:0] v2_reg [4], v2_next [4];
    logic signed [TW-1:0] t2_reg [3], t2_next [3];
    logic signed [MW-1:0] m [4];
    logic signed [MW-1:0] c [3];
    logic signed [MW-1:0] td [3];

    // stage 3
    qau_pkg::ctl_t       ctl3_reg;
    logic signed [W-1:0] a3_reg [4];
    logic signed [W-1:0] b3_reg [3];
    logic [SSW-1:0]      s3_reg;
    logic signed [VW-1:0] v3_reg [4];
    logic signed [W-1:0]  ra [3][3];
    logic signed [TW-1:0] rt [3][3];
    logic signed [LPW-1:0] rl_reg [3][3], rl_next [3][3];
    logic signed [HPW-1:0] rh_reg [3][3], rh_next [3][3];

    // stage 4
    qau_pkg::ctl_t       ctl4_reg;
    logic signed [W-1:0] a4_reg [4];
    logic signed [W-1:0] b4_reg;
    logic [SSW-1:0]      s4_reg;
    logic signed [W-1:0] r4_reg [4], r4_next [4];
    logic                sat4_reg, sat4_next;
    logic signed [VW-1:0] rpw [3][3];
    logic signed [VW-1:0] rot [3];
    logic signed [VW-1:0] v4 [4];
    logic [VW-W:0]       hi [4];
    logic [3:0]          ovf;

    // ---- stage 1: all a*b and a*a products ----
    always_comb begin
        a_zero = (a_i[0] == '0) && (a_i[1] == '0) && (a_i[2] == '0) && (a_i[3] == '0);
        ctl1_next    = ctl_i;
        ctl1_next.dz = ctl_i.vld &&
                       ((ctl_i.op == qau_pkg::OP_DIVS && b_i[0] == '0) ||
                        ((ctl_i.op == qau_pkg::OP_NRM || ctl_i.op == qau_pkg::OP_INV)
                         && a_zero));
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                p_next[i][j] = PW'(a_i[i]) * PW'(b_i[j]);
            end
            q_next[i] = PW'(a_i[i]) * PW'(a_i[i]);
        end
    end

    // ---- stage 2: product sums, cross product, simple ops ----
    always_comb begin
        m[0] = MW'(p_reg[3][0]) + MW'(p_reg[0][3]) + MW'(p_reg[1][2]) - MW'(p_reg[2][1]);
        m[1] = MW'(p_reg[3][1]) - MW'(p_reg[0][2]) + MW'(p_reg[1][3]) + MW'(p_reg[2][0]);
        m[2] = MW'(p_reg[3][2]) + MW'(p_reg[0][1]) - MW'(p_reg[1][0]) + MW'(p_reg[2][3]);
        m[3] = MW'(p_reg[3][3]) - MW'(p_reg[0][0]) - MW'(p_reg[1][1]) - MW'(p_reg[2][2]);
        c[0] = MW'(p_reg[1][2]) - MW'(p_reg[2][1]);
        c[1] = MW'(p_reg[2][0]) - MW'(p_reg[0][2]);
        c[2] = MW'(p_reg[0][1]) - MW'(p_reg[1][0]);
        for (int k = 0; k < 3; k++) begin
            td[k]      = (c[k] <<< 1) >>> F;
            t2_next[k] = td[k][TW-1:0];
        end
        s2_next = SSW'(q_reg[0]) + SSW'(q_reg[1]) + SSW'(q_reg[2]) + SSW'(q_reg[3]);
        for (int i = 0; i < 4; i++) begin
            case (ctl1_reg.op)
                qau_pkg::OP_ADD:   v2_next[i] = VW'(a1_reg[i]) + VW'(b1_reg[i]);
                qau_pkg::OP_SUB:   v2_next[i] = VW'(a1_reg[i]) - VW'(b1_reg[i]);
                qau_pkg::OP_NEG:   v2_next[i] = -VW'(a1_reg[i]);
                qau_pkg::OP_MUL:   v2_next[i] = VW'(m[i] >>> F);
                qau_pkg::OP_SCALE: v2_next[i] = VW'(p_reg[i][0] >>> F);
                qau_pkg::OP_CONJ:  v2_next[i] = (i < 3) ? -VW'(a1_reg[i]) : VW'(a1_reg[i]);
                default:           v2_next[i] = '0;
            endcase
        end
    end

    // ---- stage 3: a times t for the rotation, split over the low and high halves of t ----
    always_comb begin
        ra[0][0] = a2_reg[3]; rt[0][0] = t2_reg[0];
        ra[0][1] = a2_reg[1]; rt[0][1] = t2_reg[2];
        ra[0][2] = a2_reg[2]; rt[0][2] = t2_reg[1];
        ra[1][0] = a2_reg[3]; rt[1][0] = t2_reg[1];
        ra[1][1] = a2_reg[2]; rt[1][1] = t2_reg[0];
        ra[1][2] = a2_reg[0]; rt[1][2] = t2_reg[2];
        ra[2][0] = a2_reg[3]; rt[2][0] = t2_reg[2];
        ra[2][1] = a2_reg[0]; rt[2][1] = t2_reg[1];
        ra[2][2] = a2_reg[1]; rt[2][2] = t2_reg[0];
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                rl_next[k][j] = LPW'(ra[k][j]) * LPW'($signed({1'b0, rt[k][j][TLW-1:0]}));
                rh_next[k][j] = HPW'(ra[k][j]) * HPW'($signed(rt[k][j][TW-1:TLW]));
            end
        end
    end

    // ---- stage 4: rotation sum and clamp ----
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                rpw[k][j] = (VW'(rh_reg[k][j]) <<< TLW) + VW'(rl_reg[k][j]);
            end
            rot[k] = ((VW'(b3_reg[k]) <<< F) + rpw[k][0] + rpw[k][1] - rpw[k][2]) >>> F;
        end
        for (int i = 0; i < 4; i++) begin
            if (ctl3_reg.op == qau_pkg::OP_ROT) begin
                v4[i] = (i < 3) ? rot[i] : '0;
            end else begin
                v4[i] = v3_reg[i];
            end
            hi[i]  = v4[i][VW-1:W-1];
            ovf[i] = !((&hi[i]) || !(|hi[i]));
            if (!ovf[i]) begin
                r4_next[i] = v4[i][W-1:0];
            end else if (v4[i][VW-1]) begin
                r4_next[i] = {1'b1, {(W-1){1'b0}}};
            end else begin
                r4_next[i] = {1'b0, {(W-1){1'b1}}};
            end
        end
        sat4_next = |ovf;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end else if (adv) begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            a1_reg   <= a_i;
            b1_reg   <= b_i;
            p_reg    <= p_next;
            q_reg    <= q_next;
            a2_reg   <= a1_reg;
            for (int k = 0; k < 3; k++) begin
                b2_reg[k] <= b1_reg[k];
                b3_reg[k] <= b2_reg[k];
            end
            s2_reg   <= s2_next;
            v2_reg   <= v2_next;
            t2_reg   <= t2_next;
            a3_reg   <= a2_reg;
            s3_reg   <= s2_reg;
            v3_reg   <= v2_reg;
            rl_reg   <= rl_next;
            rh_reg   <= rh_next;
            a4_reg   <= a3_reg;
            b4_reg   <= b3_reg[0];
            s4_reg   <= s3_reg;
            r4_reg   <= r4_next;
            sat4_reg <= sat4_next;
        end
    end

    assign ctl_o = ctl4_reg;
    assign a_o   = a4_reg;
    assign b0_o  = b4_reg;
    assign s_o   = s4_reg;
    assign r_o   = r4_reg;
    assign sat_o = sat4_reg;

endmodule

`default_nettype wire

// ===== rtl/qau_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a side payload.
// Depends on qau_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module qau_sqrt #(
    parameter int W   = 32,
    parameter int PLW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  qau_pkg::ctl_t   ctl_i,
    input  logic [2*W:0]    rad_i,
    input  logic [PLW-1:0]  pl_i,
    output qau_pkg::ctl_t   ctl_o,
    output logic [W:0]      root_o,
    output logic [PLW-1:0]  pl_o
);

    localparam int SW  = W + 1;
    localparam int RDW = 2 * SW;
    localparam int RMW = SW + 3;

    qau_pkg::ctl_t  ctl_reg  [SW];
    logic [RDW-1:0] rad_reg  [SW];
    logic [RMW-1:0] rem_reg  [SW];
    logic [SW-1:0]  root_reg [SW];
    logic [PLW-1:0] pl_reg   [SW];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        qau_pkg::ctl_t  ctl_in;
        logic [RDW-1:0] rad_in;
        logic [RMW-1:0] rem_in;
        logic [SW-1:0]  root_in;
        logic [PLW-1:0] pl_in;
        logic [RMW-1:0] cand;
        logic [RMW-1:0] trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign ctl_in  = ctl_i;
            assign rad_in  = RDW'(rad_i);
            assign rem_in  = '0;
            assign root_in = '0;
            assign pl_in   = pl_i;
        end else begin : g_next
            assign ctl_in  = ctl_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign pl_in   = pl_reg[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign cand  = {rem_in[RMW-3:0], rad_in[RDW-1 -: 2]};
        assign trial = RMW'({root_in, 2'b01});
        assign ge    = (cand >= trial);

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                ctl_reg[k] <= '0;
            end else if (adv) begin
                ctl_reg[k] <= ctl_in;
            end
        end

        always_ff @(posedge clk) begin
            if (adv) begin
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= ge ? (cand - trial) : cand;
                root_reg[k] <= {root_in[SW-2:0], ge};
                pl_reg[k]   <= pl_in;
            end
        end
    end

    assign ctl_o  = ctl_reg[SW-1];
    assign root_o = root_reg[SW-1];
    assign pl_o   = pl_reg[SW-1];

endmodule

`default_nettype wire

// ===== rtl/qau_div_lane.sv =====
// One divider lane: pipelined unsigned restoring division, one quotient bit per stage.
// No package dependency; the sign and a side payload ride along.
`timescale 1ns / 1ps
`default_nettype none

module qau_div_lane #(
    parameter int NW  = 64,
    parameter int DW  = 65,
    parameter int PLW = 32
) (
    input  logic            clk,
    input  logic            adv,
    input  logic [NW-1:0]   num_i,
    input  logic [DW-1:0]   den_i,
    input  logic            neg_i,
    input  logic [PLW-1:0]  pl_i,
    output logic [NW-1:0]   quo_o,
    output logic            neg_o,
    output logic [PLW-1:0]  pl_o
);

    logic [NW-1:0]  nq_reg  [NW];
    logic [DW-1:0]  rem_reg [NW];
    logic [DW-1:0]  den_reg [NW];
    logic           neg_reg [NW];
    logic [PLW-1:0] pl_reg  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [NW-1:0]  nq_in;
        logic [DW-1:0]  rem_in;
        logic [DW-1:0]  den_in;
        logic           neg_in;
        logic [PLW-1:0] pl_in;
        logic [DW:0]    cand;
        logic [DW:0]    diff;
        logic           ge;

        if (k == 0) begin : g_first
            assign nq_in  = num_i;
            assign rem_in = '0;
            assign den_in = den_i;
            assign neg_in = neg_i;
            assign pl_in  = pl_i;
        end else begin : g_next
            assign nq_in  = nq_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign pl_in  = pl_reg[k-1];
        end

        // numerator bits leave at the top, quotient bits enter at the bottom
        assign cand = {rem_in, nq_in[NW-1]};
        assign diff = cand - {1'b0, den_in};
        assign ge   = (cand >= {1'b0, den_in});

        always_ff @(posedge clk) begin
            if (adv) begin
                nq_reg[k]  <= {nq_in[NW-2:0], ge};
                rem_reg[k] <= ge ? diff[DW-1:0] : cand[DW-1:0];
                den_reg[k] <= den_in;
                neg_reg[k] <= neg_in;
                pl_reg[k]  <= pl_in;
            end
        end
    end

    assign quo_o = nq_reg[NW-1];
    assign neg_o = neg_reg[NW-1];
    assign pl_o  = pl_reg[NW-1];

endmodule

`default_nettype wire

// ===== rtl/quaternion_arith_unit.sv =====
// Top level of the quaternion arithmetic unit: front lanes, square root, divider lanes, merge.
// Depends on qau_pkg, qau_front, qau_sqrt and qau_div_lane.
//
//   channel   signals                                   direction
//   input     in_valid, in_ready, cmd, a_x..a_w, b_x..b_w   into the unit
//   output    out_valid, out_ready, r_x..r_w, status        out of the unit
//
// One beat enters per cycle while in_ready is high; the pipeline depth is set by the
// bit-per-stage square root (DATA_WIDTH+1 stages) and divider (DATA_WIDTH +
// 2*FRAC_BITS stages) that every beat passes through.
// Reset clears all valid bits; no clearing pass is needed.
// A stalled output holds only while the last divider stage is full; bubbles still advance.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arith_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [3:0]                    cmd,
    input  logic signed [DATA_WIDTH-1:0]  a_x,
    input  logic signed [DATA_WIDTH-1:0]  a_y,
    input  logic signed [DATA_WIDTH-1:0]  a_z,
    input  logic signed [DATA_WIDTH-1:0]  a_w,
    input  logic signed [DATA_WIDTH-1:0]  b_x,
    input  logic signed [DATA_WIDTH-1:0]  b_y,
    input  logic signed [DATA_WIDTH-1:0]  b_z,
    input  logic signed [DATA_WIDTH-1:0]  b_w,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [DATA_WIDTH-1:0]  r_x,
    output logic signed [DATA_WIDTH-1:0]  r_y,
    output logic signed [DATA_WIDTH-1:0]  r_z,
    output logic signed [DATA_WIDTH-1:0]  r_w,
    output logic [1:0]                    status
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int SW  = W + 1;
    localparam int SSW = 2 * W + 1;
    localparam int NW  = W + 2 * F;
    localparam int DW  = 2 * W + 1;
    localparam int QW  = NW + 1;
    localparam int PLS = 4 * W + W + SSW + 4 * W + 1;
    localparam int AXW = SW + 1;

    logic pipe_adv;
    logic out_load;
    logic last_vld;

    // ---- front ----
    qau_pkg::ctl_t       in_ctl;
    logic signed [W-1:0] a_vec [4];
    logic signed [W-1:0] b_vec [4];
    qau_pkg::ctl_t       f_ctl;
    logic signed [W-1:0] f_a [4];
    logic signed [W-1:0] f_b0;
    logic [SSW-1:0]      f_s;
    logic signed [W-1:0] f_r [4];
    logic                f_sat;

    always_comb begin
        in_ctl     = '0;
        in_ctl.vld = in_valid;
        in_ctl.op  = qau_pkg::op_t'(cmd);
    end

    assign a_vec[0] = a_x;
    assign a_vec[1] = a_y;
    assign a_vec[2] = a_z;
    assign a_vec[3] = a_w;
    assign b_vec[0] = b_x;
    assign b_vec[1] = b_y;
    assign b_vec[2] = b_z;
    assign b_vec[3] = b_w;

    qau_front #(
        .W (W),
        .F (F)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (pipe_adv),
        .ctl_i (in_ctl),
        .a_i   (a_vec),
        .b_i   (b_vec),
        .ctl_o (f_ctl),
        .a_o   (f_a),
        .b0_o  (f_b0),
        .s_o   (f_s),
        .r_o   (f_r),
        .sat_o (f_sat)
    );

    // ---- square root ----
    logic [PLS-1:0]      sq_pl_in, sq_pl;
    qau_pkg::ctl_t       sq_ctl;
    logic [SW-1:0]       sq_root;
    logic signed [W-1:0] sq_a [4];
    logic signed [W-1:0] sq_b0;
    logic [SSW-1:0]      sq_s;
    logic signed [W-1:0] sq_r [4];
    logic                sq_sat;

    assign sq_pl_in = {f_a[0], f_a[1], f_a[2], f_a[3], f_b0, f_s,
                       f_r[0], f_r[1], f_r[2], f_r[3], f_sat};

    qau_sqrt #(
        .W   (W),
        .PLW (PLS)
    ) u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (pipe_adv),
        .ctl_i  (f_ctl),
        .rad_i  (f_s),
        .pl_i   (sq_pl_in),
        .ctl_o  (sq_ctl),
        .root_o (sq_root),
        .pl_o   (sq_pl)
    );

    assign {sq_a[0], sq_a[1], sq_a[2], sq_a[3], sq_b0, sq_s,
            sq_r[0], sq_r[1], sq_r[2], sq_r[3], sq_sat} = sq_pl;

    // ---- divider operand setup ----
    qau_pkg::ctl_t       pr_ctl_reg;
    logic [NW-1:0]       pr_num_reg [4], pr_num_next [4];
    logic                pr_neg_reg [4], pr_neg_next [4];
    logic [DW-1:0]       pr_den_reg, pr_den_next;
    logic signed [W-1:0] pr_r_reg [4];
    logic [AXW-1:0]      pr_aux_reg;
    logic [W-1:0]        amag [4];
    logic [W-1:0]        bmag;

    always_comb begin
        bmag = sq_b0[W-1] ? W'(-sq_b0) : W'(sq_b0);
        unique case (sq_ctl.op)
            qau_pkg::OP_DIVS: pr_den_next = DW'(bmag);
            qau_pkg::OP_NRM:  pr_den_next = DW'(sq_root);
            qau_pkg::OP_INV:  pr_den_next = DW'(sq_s);
            default:          pr_den_next = '0;
        endcase
        for (int i = 0; i < 4; i++) begin
            amag[i] = sq_a[i][W-1] ? W'(-sq_a[i]) : W'(sq_a[i]);
            unique case (sq_ctl.op)
                qau_pkg::OP_DIVS: begin
                    pr_num_next[i] = NW'(amag[i]) << F;
                    pr_neg_next[i] = sq_a[i][W-1] ^ sq_b0[W-1];
                end
                qau_pkg::OP_NRM: begin
                    pr_num_next[i] = NW'(amag[i]) << F;
                    pr_neg_next[i] = sq_a[i][W-1];
                end
                qau_pkg::OP_INV: begin
                    pr_num_next[i] = NW'(amag[i]) << (2 * F);
                    // conjugate: vector part flips sign
                    pr_neg_next[i] = (i < 3) ? (!sq_a[i][W-1] && (sq_a[i] != '0))
                                             : sq_a[i][W-1];
                end
                default: begin
                    pr_num_next[i] = '0;
                    pr_neg_next[i] = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pr_ctl_reg <= '0;
        end else if (pipe_adv) begin
            pr_ctl_reg <= sq_ctl;
        end
    end

    always_ff @(posedge clk) begin
        if (pipe_adv) begin
            pr_num_reg <= pr_num_next;
            pr_neg_reg <= pr_neg_next;
            pr_den_reg <= pr_den_next;
            pr_r_reg   <= sq_r;
            pr_aux_reg <= {sq_root, sq_sat};
        end
    end

    // ---- divider lanes ----
    logic [NW-1:0]       d_quo [4];
    logic                d_neg [4];
    logic [W-1:0]        d_r [4];
    qau_pkg::ctl_t       dl_ctl_reg [NW];
    logic [AXW-1:0]      dl_aux_reg [NW];

    for (genvar i = 0; i < 4; i++) begin : g_lane
        qau_div_lane #(
            .NW  (NW),
            .DW  (DW),
            .PLW (W)
        ) u_div (
            .clk   (clk),
            .adv   (pipe_adv),
            .num_i (pr_num_reg[i]),
            .den_i (pr_den_reg),
            .neg_i (pr_neg_reg[i]),
            .pl_i  (pr_r_reg[i]),
            .quo_o (d_quo[i]),
            .neg_o (d_neg[i]),
            .pl_o  (d_r[i])
        );
    end

    // control and root ride beside the divider lanes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < NW; k++) begin
                dl_ctl_reg[k] <= '0;
            end
        end else if (pipe_adv) begin
            dl_ctl_reg[0] <= pr_ctl_reg;
            for (int k = 1; k < NW; k++) begin
                dl_ctl_reg[k] <= dl_ctl_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (pipe_adv) begin
            dl_aux_reg[0] <= pr_aux_reg;
            for (int k = 1; k < NW; k++) begin
                dl_aux_reg[k] <= dl_aux_reg[k-1];
            end
        end
    end

    // ---- merge and output register ----
    qau_pkg::ctl_t        m_ctl;
    logic [SW-1:0]        m_root;
    logic                 m_sat;
    logic signed [QW-1:0] qs [4];
    logic [QW-W:0]        qhi [4];
    logic [3:0]           qovf;
    logic signed [W-1:0]  qv [4];
    logic signed [W-1:0]  rootv;
    logic                 root_ovf;
    logic signed [W-1:0]  res_next [4];
    logic [1:0]           status_next;
    logic                 out_valid_reg;
    logic signed [W-1:0]  res_reg [4];
    logic [1:0]           status_reg;

    assign m_ctl           = dl_ctl_reg[NW-1];
    assign {m_root, m_sat} = dl_aux_reg[NW-1];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qs[i]   = d_neg[i] ? -QW'(d_quo[i]) : QW'(d_quo[i]);
            qhi[i]  = qs[i][QW-1:W-1];
            qovf[i] = !((&qhi[i]) || !(|qhi[i]));
            if (!qovf[i]) begin
                qv[i] = qs[i][W-1:0];
            end else if (qs[i][QW-1]) begin
                qv[i] = {1'b1, {(W-1){1'b0}}};
            end else begin
                qv[i] = {1'b0, {(W-1){1'b1}}};
            end
        end
        root_ovf = |m_root[W:W-1];
        rootv    = root_ovf ? {1'b0, {(W-1){1'b1}}} : m_root[W-1:0];

        for (int i = 0; i < 4; i++) begin
            res_next[i] = '0;
        end
        status_next = qau_pkg::ST_OK;
        if (m_ctl.dz) begin
            status_next = qau_pkg::ST_DZ;
        end else begin
            unique case (m_ctl.op) inside
                qau_pkg::OP_DIVS, qau_pkg::OP_NRM, qau_pkg::OP_INV: begin
                    res_next    = qv;
                    status_next = (|qovf) ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
                end
                qau_pkg::OP_NORM: begin
                    res_next[3] = rootv;
                    status_next = root_ovf ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
                end
                qau_pkg::OP_ADD, qau_pkg::OP_SUB, qau_pkg::OP_NEG, qau_pkg::OP_MUL,
                qau_pkg::OP_SCALE, qau_pkg::OP_CONJ, qau_pkg::OP_ROT: begin
                    for (int i = 0; i < 4; i++) begin
                        res_next[i] = d_r[i];
                    end
                    status_next = m_sat ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
                end
                default: begin
                    status_next = qau_pkg::ST_OK;
                end
            endcase
        end
    end

    assign last_vld = m_ctl.vld;
    assign out_load = !out_valid_reg || out_ready;
    // advance while the last stage is empty, even with a result waiting
    assign pipe_adv = out_load || !last_vld;
    assign in_ready = pipe_adv;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= last_vld;
        end
    end

    always_ff @(posedge clk) begin
        if (out_load) begin
            res_reg    <= res_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign r_x       = res_reg[0];
    assign r_y       = res_reg[1];
    assign r_z       = res_reg[2];
    assign r_w       = res_reg[3];
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == qau_pkg::ST_DZ) |->
            (r_x == '0) && (r_y == '0) && (r_z == '0) && (r_w == '0))
        else $error("division-by-zero beat with nonzero result");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
        last_vld && out_load |=> out_valid)
        else $error("finished beat did not reach the output register");
`endif

endmodule

`default_nettype wire

// ===== tb/quaternion_arith_unit_checker.sv =====
// Checker for the quaternion arithmetic unit: watches both channels, predicts each result
// and compares it with what comes out. Depends on qau_pkg for opcodes and status codes.
`timescale 1ns / 1ps

module quaternion_arith_unit_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [3:0]         cmd,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] a_w,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] b_w,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] r_x,
    input  logic signed [31:0] r_y,
    input  logic signed [31:0] r_z,
    input  logic signed [31:0] r_w,
    input  logic [1:0]         status,
    output int                 mismatches,
    output int                 pending
);

    localparam int FRAC = 16;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic [1:0]  st;
    } quat_res_t;

    localparam wide_t VMAX = 128'sd2147483647;
    localparam wide_t VMIN = -128'sd2147483648;

    quat_res_t expected_q[$];

    function automatic wide_t floor_sqrt(wide_t s);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int k = 48; k >= 0; k--)
        begin
            c = r | (128'd1 << k);
            if (c * c <= s)
                r = c;
        end
        return wide_t'(r);
    endfunction

    function automatic logic [31:0] clamp(wide_t v, inout logic flag);
        if (v < VMIN)
        begin
            flag = 1'b1;
            return VMIN[31:0];
        end
        if (v > VMAX)
        begin
            flag = 1'b1;
            return VMAX[31:0];
        end
        return v[31:0];
    endfunction

    function automatic quat_res_t predict_quat(logic [3:0] op,
            logic signed [31:0] ax, logic signed [31:0] ay,
            logic signed [31:0] az, logic signed [31:0] aw,
            logic signed [31:0] bx, logic signed [31:0] by,
            logic signed [31:0] bz, logic signed [31:0] bw);
        wide_t a[4];
        wide_t b[4];
        wide_t v[4];
        wide_t t[3];
        wide_t s;
        wide_t n;
        wide_t tmp;
        logic flag;
        logic dz;
        logic used;
        quat_res_t r;
        a[0] = ax; a[1] = ay; a[2] = az; a[3] = aw;
        b[0] = bx; b[1] = by; b[2] = bz; b[3] = bw;
        for (int i = 0; i < 4; i++)
            v[i] = '0;
        flag = 1'b0;
        dz   = 1'b0;
        used = 1'b1;
        s    = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
        case (op)
            qau_pkg::OP_ADD:   for (int i = 0; i < 4; i++) v[i] = a[i] + b[i];
            qau_pkg::OP_SUB:   for (int i = 0; i < 4; i++) v[i] = a[i] - b[i];
            qau_pkg::OP_NEG:   for (int i = 0; i < 4; i++) v[i] = -a[i];
            qau_pkg::OP_MUL:
            begin
                v[0] = (a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1]) >>> FRAC;
                v[1] = (a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0]) >>> FRAC;
                v[2] = (a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3]) >>> FRAC;
                v[3] = (a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2]) >>> FRAC;
            end
            qau_pkg::OP_SCALE: for (int i = 0; i < 4; i++) v[i] = (a[i] * b[0]) >>> FRAC;
            qau_pkg::OP_DIVS:
                if (b[0] == 0)
                    dz = 1'b1;
                else
                    for (int i = 0; i < 4; i++) v[i] = (a[i] <<< FRAC) / b[0];
            qau_pkg::OP_CONJ:
            begin
                for (int i = 0; i < 3; i++) v[i] = -a[i];
                v[3] = a[3];
            end
            qau_pkg::OP_NORM:  v[3] = floor_sqrt(s);
            qau_pkg::OP_NRM:
            begin
                n = floor_sqrt(s);
                if (n == 0)
                    dz = 1'b1;
                else
                    for (int i = 0; i < 4; i++) v[i] = (a[i] <<< FRAC) / n;
            end
            qau_pkg::OP_INV:
                if (s == 0)
                    dz = 1'b1;
                else
                    for (int i = 0; i < 4; i++)
                        v[i] = (i < 3 ? -(a[i] <<< (2*FRAC)) : (a[i] <<< (2*FRAC))) / s;
            qau_pkg::OP_ROT:
            begin
                t[0] = a[1]*b[2] - a[2]*b[1];
                t[1] = a[2]*b[0] - a[0]*b[2];
                t[2] = a[0]*b[1] - a[1]*b[0];
                // keep the low 64 bits of the doubled cross product shifted down by FRAC, unclamped
                for (int i = 0; i < 3; i++)
                begin
                    tmp  = (t[i] + t[i]) >>> FRAC;
                    t[i] = $signed(tmp[63:0]);
                end
                v[0] = a[3]*t[0] + a[1]*t[2] - a[2]*t[1];
                v[1] = a[3]*t[1] + a[2]*t[0] - a[0]*t[2];
                v[2] = a[3]*t[2] + a[0]*t[1] - a[1]*t[0];
                for (int i = 0; i < 3; i++)
                    v[i] = ((b[i] <<< FRAC) + v[i]) >>> FRAC;
            end
            default:  used = 1'b0;
        endcase
        r = '0;
        if (used && !dz)
        begin
            r.x = clamp(v[0], flag);
            r.y = clamp(v[1], flag);
            r.z = clamp(v[2], flag);
            r.w = clamp(v[3], flag);
        end
        r.st = dz ? qau_pkg::ST_DZ : (flag ? qau_pkg::ST_SAT : qau_pkg::ST_OK);
        return r;
    endfunction

    quat_res_t want;
    quat_res_t got;

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_q.push_back(predict_quat(cmd, a_x, a_y, a_z, a_w,
                                                  b_x, b_y, b_z, b_w));
            if (out_valid && out_ready)
            begin
                got = '{r_x, r_y, r_z, r_w, status};
                if (expected_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("ERROR %0t: result beat with nothing expected", $realtime);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display({"ERROR %0t: exp x=%h y=%h z=%h w=%h st=%0d",
                                      " got x=%h y=%h z=%h w=%h st=%0d"}, $realtime,
                                     want.x, want.y, want.z, want.w, want.st,
                                     got.x, got.y, got.z, got.w, got.st);
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== tb/quaternion_arith_unit_tb.sv =====
// Top of the quaternion arithmetic unit testbench: clock, reset, stimulus and verdict.
// Depends on qau_pkg, quaternion_arith_unit and quaternion_arith_unit_checker.
`timescale 1ns / 1ps

module quaternion_arith_unit_tb;

    localparam int NUM_RANDOM = 1650;
    localparam int LATENCY    = 110;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [3:0]         cmd;
    logic signed [31:0] a_x, a_y, a_z, a_w;
    logic signed [31:0] b_x, b_y, b_z, b_w;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] r_x, r_y, r_z, r_w;
    logic [1:0]         status;
    int                 mismatches;
    int                 pending;

    logic idle_on;
    logic hold_req;

    quaternion_arith_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
        .out_valid(out_valid), .out_ready(out_ready),
        .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w), .status(status)
    );

    quaternion_arith_unit_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
        .out_valid(out_valid), .out_ready(out_ready),
        .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w), .status(status),
        .mismatches(mismatches), .pending(pending)
    );

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    initial
    begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Operand mix: extremes, zero, full range, and small values near unity.
    function automatic logic signed [31:0] pick_val();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'sd0;
            3, 4, 5: return $urandom;
            default: return $signed($urandom_range(32'h80000)) - 32'sh40000;
        endcase
    endfunction

    // Present one beat and hold it until it is taken.
    task automatic send_quat(logic [3:0] op, logic signed [31:0] ax, logic signed [31:0] ay,
                             logic signed [31:0] az, logic signed [31:0] aw,
                             logic signed [31:0] bx, logic signed [31:0] by,
                             logic signed [31:0] bz, logic signed [31:0] bw);
        cmd      <= op;
        a_x      <= ax; a_y <= ay; a_z <= az; a_w <= aw;
        b_x      <= bx; b_y <= by; b_z <= bz; b_w <= bw;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (idle_on && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_random();
        logic [3:0] op;
        op = ($urandom_range(19) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(10));
        send_quat(op, pick_val(), pick_val(), pick_val(), pick_val(),
                  pick_val(), pick_val(), pick_val(), pick_val());
    endtask

    // Receiver: random backpressure, plus one long hold counted here.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_ready <= idle_on ? ($urandom_range(99) >= 34) : 1'b1;
                @(posedge clk);
            end
        end
    end

    localparam logic signed [31:0] QMAX = 32'sh7fffffff;
    localparam logic signed [31:0] QMIN = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;
    localparam logic signed [31:0] HALF = 32'sh00008000;

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = '0;
        {a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w} = '0;
        idle_on  = 1'b0;
        hold_req = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_quat(qau_pkg::OP_ADD, QMAX, QMIN, ONE, -ONE, QMAX, QMIN, -ONE, ONE);
        send_quat(qau_pkg::OP_SUB, QMIN, QMAX, 0, ONE, QMAX, QMIN, 0, HALF);
        send_quat(qau_pkg::OP_NEG, QMIN, QMAX, 0, -ONE, 0, 0, 0, 0);
        send_quat(qau_pkg::OP_MUL, ONE, 0, 0, 0, 0, ONE, 0, 0);
        send_quat(qau_pkg::OP_MUL, QMAX, QMIN, QMAX, QMIN, QMIN, QMIN, QMAX, QMAX);
        send_quat(qau_pkg::OP_MUL, -HALF, HALF, ONE, ONE, -1, 3, ONE, -ONE);
        send_quat(qau_pkg::OP_SCALE, QMAX, QMIN, ONE, -1, QMIN, 0, 0, 0);
        send_quat(qau_pkg::OP_SCALE, ONE, -ONE, HALF, 3, HALF, 0, 0, 0);
        send_quat(qau_pkg::OP_DIVS, ONE, -ONE, QMAX, QMIN, 0, ONE, ONE, ONE);
        send_quat(qau_pkg::OP_DIVS, ONE, -ONE, 7, -7, 3 * ONE, 0, 0, 0);
        send_quat(qau_pkg::OP_DIVS, QMAX, QMIN, ONE, 0, 1, 0, 0, 0);
        send_quat(qau_pkg::OP_CONJ, QMIN, QMAX, -ONE, QMIN, 0, 0, 0, 0);
        send_quat(qau_pkg::OP_NORM, QMIN, QMIN, QMIN, QMIN, 0, 0, 0, 0);
        send_quat(qau_pkg::OP_NORM, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0);
        send_quat(qau_pkg::OP_NRM, 0, 0, 0, 0, 0, 0, 0, 0);
        send_quat(qau_pkg::OP_NRM, 1, 0, 0, 0, 0, 0, 0, 0);
        send_quat(qau_pkg::OP_NRM, -3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0);
        send_quat(qau_pkg::OP_INV, 0, 0, 0, 0, 0, 0, 0, 0);
        send_quat(qau_pkg::OP_INV, 0, 0, 0, 1, 0, 0, 0, 0);
        send_quat(qau_pkg::OP_INV, HALF, -HALF, HALF, HALF, 0, 0, 0, 0);
        send_quat(qau_pkg::OP_ROT, 0, 0, 0, ONE, ONE, -ONE, QMAX, 0);
        send_quat(qau_pkg::OP_ROT, 0, 0, HALF, HALF, ONE, 2 * ONE, 0, 0);
        send_quat(qau_pkg::OP_ROT, QMAX, QMIN, QMAX, QMIN, QMIN, QMAX, QMIN, 0);
        send_quat(4'd11, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
        send_quat(4'd15, QMIN, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX);

        for (int k = 0; k < NUM_RANDOM; k++)
        begin
            if (k == 400)
                idle_on = 1'b1;
            if (k == 700)
                hold_req = 1'b1;
            if (k == 1100)
            begin
                // pause the sender until the pipeline has drained
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            if (k == 1400)
                idle_on = 1'b0;
            if (k == 1500)
                idle_on = 1'b1;
            send_random();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
